### rtl/core/coclustering_similarity_assert.svh
// ----------------------------------------------------------------------------
// Co-clustering similarity assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef COCLUSTERING_SIMILARITY_ASSERT_SVH
`define COCLUSTERING_SIMILARITY_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define CSIM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion on the block's own clock and reset.
`define CSIM_ASSERT(lbl, prop, msg) \
    `CSIM_ASSERT_RST(lbl, i_clk, i_rst_n, prop, msg)

`endif

### rtl/core/csim_pkg.sv
// ----------------------------------------------------------------------------
// Co-clustering similarity package
// Request and response types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package csim_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b1;

    // Register widths and reset values
    localparam int ITERS_W  = 9;
    localparam int POINTS_W = 7;
    localparam logic [ITERS_W-1:0]  ITERS_RESET  = 9'd256;
    localparam logic [POINTS_W-1:0] POINTS_RESET = 7'd64;

    // Request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result widths; similarity is unsigned 1.16 fixed point
    localparam int COUNT_W = 9;
    localparam int SIM_W   = 17;
    localparam logic [SIM_W-1:0] SIM_ONE = 17'd65536;
    localparam int STEP_W  = $clog2(SIM_W);

    typedef struct packed {
        logic       func;
        logic [5:0] point_a;
        logic [5:0] point_b;
        logic [7:0] iteration;
        logic [7:0] label;
    } t_in_req;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic [SIM_W-1:0]   similarity;
        logic               index_error;
    } t_out_rsp;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### rtl/core/csim_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module csim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port and both registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/csim_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving floor(dividend * 65536 / divisor) for a dividend
// no larger than the divisor, one quotient bit per cycle, 17 bits in all.
// ----------------------------------------------------------------------------
module csim_div
    import csim_pkg::*;
#(
    parameter int W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_dividend,
    input  logic [W-1:0]     i_divisor,
    output t_div_stat        o_stat,
    output logic [SIM_W-1:0] o_quotient
);

    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_div;
    logic [SIM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [W:0] trial;
    logic       ge;
    logic [W:0] diff;

    // Shared compare and subtract: the first step takes the dividend as it
    // stands (integer bit), later steps double the partial remainder.
    always_comb begin
        trial = (r_step == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        ge    = (trial >= {1'b0, r_div});
        diff  = ge ? (trial - {1'b0, r_div}) : trial;
    end

    // Step sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_dividend;
                r_div  <= i_divisor;
                r_quo  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= W'(diff);
                r_quo <= {r_quo[SIM_W-2:0], ge};
                if (r_step == STEP_W'(SIM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

### rtl/core/coclustering_similarity.sv
// ----------------------------------------------------------------------------
// Co-clustering similarity store
// Label store per point and iteration, with pair queries that count shared
// labels and return the fraction of matching iterations.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on i_in_valid / o_in_ready. A load request (func = 0) writes
// one label; a query (func = 1) compares two points over the first
// iterations_used iterations. Each request gives exactly one response on
// o_out_valid / i_out_ready, with index_error set and zero fields when an
// index lies beyond the configured counts.
// A load or a rejected request goes straight to the finishing state, which
// loads the response register once that is free. A query first scans, reading
// one label pair per cycle through the two read ports of the store, then runs
// the divider (start, one quotient bit per step, done) before the finishing
// state loads the response register. One request is in progress at a time;
// o_in_ready is high only when idle, so a new request is taken only once the
// last one has loaded the response register.
// While the receiver stalls, the response register holds its result, one more
// request is taken and worked through, and it then waits with o_in_ready low.
// Reset returns iterations_used to 256 and points_used to 64 and empties the
// response register. The label store is not cleared: only loaded entries may
// be queried. Configuration writes take effect at once. The user must make
// them while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module coclustering_similarity
    import csim_pkg::*;
#(
    parameter int MAX_POINTS     = 64,
    parameter int MAX_ITERATIONS = 256,
    parameter int LABEL_BITS     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_rsp              o_out_rsp
);

    localparam int DEPTH = MAX_POINTS * MAX_ITERATIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ITERATIONS + 1);
    localparam int PW    = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [ITERS_W-1:0]    r_cfg_iters;
    logic [POINTS_W-1:0]   r_cfg_points;
    logic [5:0]            r_pa;
    logic [5:0]            r_pb;
    logic [CW-1:0]         r_iters;
    logic [CW-1:0]         r_k;
    logic [CW-1:0]         r_count;
    logic                  r_pend;
    logic                  r_use_div;
    logic                  r_err;
    logic                  r_div_start;
    logic                  r_out_valid;
    t_out_rsp              r_out_rsp;

    logic [CW-1:0]         iters_eff;
    logic [PW-1:0]         pts_eff;
    logic                  wr_err;
    logic                  q_err;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [LABEL_BITS-1:0] ram_wdata;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [LABEL_BITS-1:0] rdata_a;
    logic [LABEL_BITS-1:0] rdata_b;
    logic                  scan_issue;
    t_div_stat             div_stat;
    logic [SIM_W-1:0]      div_quo;

    // Registers as written, limited to the range the store supports.
    always_comb begin
        if (r_cfg_iters == '0) begin
            iters_eff = CW'(1);
        end else if (32'(r_cfg_iters) > MAX_ITERATIONS) begin
            iters_eff = CW'(MAX_ITERATIONS);
        end else begin
            iters_eff = CW'(r_cfg_iters);
        end
        if (r_cfg_points == '0) begin
            pts_eff = PW'(1);
        end else if (32'(r_cfg_points) > MAX_POINTS) begin
            pts_eff = PW'(MAX_POINTS);
        end else begin
            pts_eff = PW'(r_cfg_points);
        end
    end

    // Index checks on the incoming request.
    always_comb begin
        wr_err = (32'(i_in_req.point_a) >= 32'(pts_eff))
              || (32'(i_in_req.iteration) >= 32'(iters_eff));
        q_err  = (32'(i_in_req.point_a) >= 32'(pts_eff))
              || (32'(i_in_req.point_b) >= 32'(pts_eff));
    end

    // Store write on an accepted, in-range load.
    always_comb begin
        ram_we    = (r_state == S_IDLE) && i_in_valid
                 && (i_in_req.func == FUNC_LOAD) && !wr_err;
        ram_waddr = AW'(32'(i_in_req.point_a) * MAX_ITERATIONS
                 + 32'(i_in_req.iteration));
        ram_wdata = LABEL_BITS'(i_in_req.label);
    end

    // Scan addresses: one iteration column of both points per cycle.
    always_comb begin
        scan_issue = (r_k < r_iters);
        raddr_a    = AW'(32'(r_pa) * MAX_ITERATIONS + 32'(r_k));
        raddr_b    = AW'(32'(r_pb) * MAX_ITERATIONS + 32'(r_k));
    end

    csim_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    csim_div #(
        .W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_count),
        .i_divisor  (r_iters),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Sequencer, configuration registers and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_iters  <= ITERS_RESET;
            r_cfg_points <= POINTS_RESET;
            r_pend       <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ITERS:  r_cfg_iters  <= ITERS_W'(i_cfg_data);
                    CFG_POINTS: r_cfg_points <= POINTS_W'(i_cfg_data);
                endcase
            end

            // The response register fills from the finishing state and empties
            // when its response is taken.
            if ((r_state == S_FINISH) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Divider start pulse once the scan has drained.
            r_div_start <= (r_state == S_SCAN) && !scan_issue && !r_pend;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pa    <= i_in_req.point_a;
                        r_pb    <= i_in_req.point_b;
                        r_iters <= iters_eff;
                        r_k     <= '0;
                        r_count <= '0;
                        r_pend  <= 1'b0;
                        if (i_in_req.func == FUNC_QUERY && !q_err) begin
                            r_use_div <= 1'b1;
                            r_err     <= 1'b0;
                            r_state   <= S_SCAN;
                        end else begin
                            r_use_div <= 1'b0;
                            r_err     <= (i_in_req.func == FUNC_LOAD) ? wr_err : q_err;
                            r_state   <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue the next pair while columns remain.
                    if (scan_issue) begin
                        r_k    <= r_k + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // Compare the pair read in the previous cycle.
                    if (r_pend && (rdata_a == rdata_b)) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (!scan_issue && !r_pend) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_rsp.match_count <= COUNT_W'(r_count);
                        r_out_rsp.similarity  <= r_use_div ? div_quo : '0;
                        r_out_rsp.index_error <= r_err;
                        r_state               <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

### rtl/core/csim_chk.sv
// ----------------------------------------------------------------------------
// Co-clustering similarity port checker
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
`include "coclustering_similarity_assert.svh"

module csim_chk
    import csim_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_rsp o_out_rsp
);

    // A pending response is not withdrawn before it is taken.
    `CSIM_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "response dropped")

    // One request at a time: acceptance closes the request channel.
    `CSIM_ASSERT(a_one_req, i_in_valid && o_in_ready |=> !o_in_ready, "second request taken")

    // A rejected request carries no count and no fraction.
    `CSIM_ASSERT(a_err_zero, o_out_valid && o_out_rsp.index_error |-> (o_out_rsp.match_count == '0) && (o_out_rsp.similarity == '0), "error response not zero")

    // The fraction never exceeds one.
    `CSIM_ASSERT(a_sim_max, o_out_valid |-> (o_out_rsp.similarity <= SIM_ONE), "similarity above one")

    // No matches give a zero fraction.
    `CSIM_ASSERT(a_zero_cnt, o_out_valid && (o_out_rsp.match_count == '0) |-> (o_out_rsp.similarity == '0), "fraction without matches")

endmodule

bind coclustering_similarity csim_chk u_csim_chk (.*);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Co-clustering similarity testbench
// Loads cluster labels and issues pair queries through the request channel,
// predicts every response from its own copy of the label store and registers,
// and checks each response field by field. The run steps through several
// point and iteration counts, the out-of-range register values among them,
// with random idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import csim_pkg::*;

    localparam int MAX_PTS     = 64;
    localparam int MAX_ITERS   = 256;
    localparam int CYCLE_LIMIT = 2000000;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_ITERS;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    t_in_req               in_req     = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    t_out_rsp              out_rsp;

    // Predicted register and label store contents
    logic [ITERS_W-1:0]  cfg_iters_q  = ITERS_RESET;
    logic [POINTS_W-1:0] cfg_points_q = POINTS_RESET;
    logic [7:0]          label_mem [MAX_PTS][MAX_ITERS];

    // Entries loaded so far, as seen when requests are generated
    bit loaded_map [MAX_PTS][MAX_ITERS];
    int gen_iters = MAX_ITERS;
    int gen_pts   = MAX_PTS;

    t_in_req  req_pend_q [$];
    t_out_rsp sim_expect_q [$];

    bit req_taken  = 1'b0;
    bit idle_on    = 1'b1;
    bit hold_start = 1'b0;
    bit failed     = 1'b0;
    int in_gap     = 0;
    int out_gap    = 0;
    int hold_left  = 0;
    int cycle_cnt  = 0;

    coclustering_similarity #(
        .MAX_POINTS     (MAX_PTS),
        .MAX_ITERATIONS (MAX_ITERS),
        .LABEL_BITS     (8)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A register value of zero acts as one, and anything above the maximum as
    // the maximum.
    function automatic int clamp_count(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Expected response to one request; a load also updates the label store.
    function automatic t_out_rsp similarity_response(t_in_req r);
        t_out_rsp rsp;
        int       iters;
        int       pts;
        int       hits;
        iters = clamp_count(int'(cfg_iters_q), MAX_ITERS);
        pts   = clamp_count(int'(cfg_points_q), MAX_PTS);
        rsp   = '0;
        hits  = 0;
        if (r.func == FUNC_LOAD) begin
            if (r.point_a >= pts || r.iteration >= iters) begin
                rsp.index_error = 1'b1;
            end else begin
                label_mem[r.point_a][r.iteration] = r.label;
            end
        end else if (r.point_a >= pts || r.point_b >= pts) begin
            rsp.index_error = 1'b1;
        end else begin
            for (int k = 0; k < iters; k++) begin
                if (label_mem[r.point_a][k] == label_mem[r.point_b][k]) hits++;
            end
            rsp.match_count = hits[COUNT_W-1:0];
            rsp.similarity  = SIM_W'((hits * int'(SIM_ONE)) / iters);
        end
        return rsp;
    endfunction

    // First iteration of a point that has not been loaded yet, or gen_iters
    // when the whole row in use is loaded.
    function automatic int first_gap(int p);
        for (int k = 0; k < gen_iters; k++) begin
            if (!loaded_map[p][k]) return k;
        end
        return gen_iters;
    endfunction

    // Mostly a point from a small working set, so that rows fill up quickly.
    function automatic int pick_point(int pool);
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, gen_pts - 1);
        return $urandom_range(0, pool - 1);
    endfunction

    function automatic void queue_request(t_in_req r);
        if (r.func == FUNC_LOAD && r.point_a < gen_pts && r.iteration < gen_iters) begin
            loaded_map[r.point_a][r.iteration] = 1'b1;
        end
        req_pend_q.push_back(r);
    endfunction

    // Random requests: rows are filled before they are queried, with a share
    // of requests carrying an index beyond the configured counts.
    task automatic gen_random(input int n_items);
        t_in_req r;
        int      pool;
        int      k;
        pool = (gen_iters > 64) ? 2 : 6;
        if (pool > gen_pts) pool = gen_pts;
        for (int i = 0; i < n_items; i++) begin
            r = t_in_req'($urandom);
            if ($urandom_range(0, 9) == 0 && (gen_pts < MAX_PTS || gen_iters < MAX_ITERS)) begin
                if (gen_pts < MAX_PTS && (gen_iters == MAX_ITERS || $urandom_range(0, 1) == 0)) begin
                    if (r.func == FUNC_QUERY && $urandom_range(0, 1) == 0) begin
                        r.point_b = 6'($urandom_range(gen_pts, MAX_PTS - 1));
                    end else begin
                        r.point_a = 6'($urandom_range(gen_pts, MAX_PTS - 1));
                    end
                end else begin
                    r.func      = FUNC_LOAD;
                    r.point_a   = 6'($urandom_range(0, gen_pts - 1));
                    r.iteration = 8'($urandom_range(gen_iters, MAX_ITERS - 1));
                end
            end else begin
                r.point_a = 6'(pick_point(pool));
                r.point_b = 6'(pick_point(pool));
                if ($urandom_range(0, 9) < 4 && first_gap(r.point_a) == gen_iters
                        && first_gap(r.point_b) == gen_iters) begin
                    r.func = FUNC_QUERY;
                end else begin
                    r.func = FUNC_LOAD;
                    k = first_gap(r.point_a);
                    r.iteration = (k < gen_iters) ? 8'(k)
                                                  : 8'($urandom_range(0, gen_iters - 1));
                    r.label = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 2));
                end
            end
            queue_request(r);
        end
    endtask

    // Writes both registers; entered just after a falling edge, left on a rising edge.
    task automatic set_counts(input int iters, input int pts);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ITERS;
        cfg_data <= CFG_DATA_W'(iters);
        @(negedge clk);
        cfg_idx  <= CFG_POINTS;
        cfg_data <= CFG_DATA_W'(pts);
        @(negedge clk);
        cfg_we    <= 1'b0;
        gen_iters = clamp_count(iters, MAX_ITERS);
        gen_pts   = clamp_count(pts, MAX_PTS);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (req_pend_q.size() != 0 || sim_expect_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input int iters, input int pts, input int n_items);
        set_counts(iters, pts);
        gen_random(n_items);
        wait_drained();
    endtask

    // Request driver: the head of the pending queue is offered until taken.
    always @(negedge clk) begin
        if (req_taken) void'(req_pend_q.pop_front());
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            if (idle_on && in_gap == 0 && $urandom_range(0, 15) == 0) begin
                in_gap = $urandom_range(1, 9);
            end
            if (in_gap != 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (req_pend_q.size() != 0) begin
                in_valid <= 1'b1;
                in_req   <= req_pend_q[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Response sink, with random stalls and one long hold-off.
    always @(negedge clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = 300;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (idle_on && out_gap == 0 && $urandom_range(0, 15) == 0) begin
                out_gap = $urandom_range(1, 9);
            end
            if (out_gap != 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: tracks register writes, predicts on each accepted request and
    // checks each accepted response against the oldest prediction.
    always @(posedge clk) begin : rsp_monitor
        t_out_rsp want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            req_taken = rst_n && in_valid && in_ready;
            if (!rst_n) begin
                cfg_iters_q  = ITERS_RESET;
                cfg_points_q = POINTS_RESET;
            end else if (cfg_we) begin
                if (cfg_idx == CFG_ITERS) cfg_iters_q = cfg_data;
                else if (cfg_idx == CFG_POINTS) cfg_points_q = cfg_data[POINTS_W-1:0];
            end
            if (req_taken) sim_expect_q.push_back(similarity_response(in_req));
            if (rst_n && out_valid && out_ready) begin
                if (sim_expect_q.size() == 0) begin
                    $error("Response with no request outstanding");
                    failed = 1'b1;
                end else begin
                    want = sim_expect_q.pop_front();
                    if (out_rsp.match_count !== want.match_count) begin
                        $error("match_count: expected %0d, got %0d",
                               want.match_count, out_rsp.match_count);
                        failed = 1'b1;
                    end
                    if (out_rsp.similarity !== want.similarity) begin
                        $error("similarity: expected %0d, got %0d",
                               want.similarity, out_rsp.similarity);
                        failed = 1'b1;
                    end
                    if (out_rsp.index_error !== want.index_error) begin
                        $error("index_error: expected %0d, got %0d",
                               want.index_error, out_rsp.index_error);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: four iterations over eight points.
        set_counts(4, 8);
        queue_request(t_in_req'{FUNC_LOAD, 6'd0, 6'd63, 8'd0, 8'd0});
        queue_request(t_in_req'{FUNC_LOAD, 6'd0, 6'd0, 8'd1, 8'd255});
        queue_request(t_in_req'{FUNC_LOAD, 6'd0, 6'd0, 8'd2, 8'd7});
        queue_request(t_in_req'{FUNC_LOAD, 6'd0, 6'd0, 8'd3, 8'd7});
        queue_request(t_in_req'{FUNC_LOAD, 6'd1, 6'd21, 8'd0, 8'd0});
        queue_request(t_in_req'{FUNC_LOAD, 6'd1, 6'd0, 8'd1, 8'd255});
        queue_request(t_in_req'{FUNC_LOAD, 6'd1, 6'd0, 8'd2, 8'd8});
        queue_request(t_in_req'{FUNC_LOAD, 6'd1, 6'd0, 8'd3, 8'd7});
        queue_request(t_in_req'{FUNC_LOAD, 6'd7, 6'd0, 8'd0, 8'h55});
        queue_request(t_in_req'{FUNC_LOAD, 6'd7, 6'd0, 8'd1, 8'hAA});
        queue_request(t_in_req'{FUNC_LOAD, 6'd7, 6'd0, 8'd2, 8'd1});
        queue_request(t_in_req'{FUNC_LOAD, 6'd7, 6'd0, 8'd3, 8'd2});
        // A point against itself gives exactly one; point 0 against point 1 gives a fraction, against point 7 zero.
        queue_request(t_in_req'{FUNC_QUERY, 6'd0, 6'd0, 8'd255, 8'd255});
        queue_request(t_in_req'{FUNC_QUERY, 6'd0, 6'd1, 8'd0, 8'd0});
        queue_request(t_in_req'{FUNC_QUERY, 6'd0, 6'd7, 8'd17, 8'd99});
        queue_request(t_in_req'{FUNC_QUERY, 6'd7, 6'd7, 8'd0, 8'd0});
        // Indexes at and beyond the configured counts.
        queue_request(t_in_req'{FUNC_LOAD, 6'd63, 6'd0, 8'd0, 8'd9});
        queue_request(t_in_req'{FUNC_LOAD, 6'd2, 6'd0, 8'd255, 8'd3});
        queue_request(t_in_req'{FUNC_LOAD, 6'd3, 6'd0, 8'd4, 8'd3});
        queue_request(t_in_req'{FUNC_LOAD, 6'd8, 6'd0, 8'd0, 8'd1});
        queue_request(t_in_req'{FUNC_QUERY, 6'd0, 6'd63, 8'd0, 8'd0});
        queue_request(t_in_req'{FUNC_QUERY, 6'd8, 6'd0, 8'd0, 8'd0});
        queue_request(t_in_req'{FUNC_QUERY, 6'd63, 6'd63, 8'd255, 8'd255});
        wait_drained();

        // Zero in both registers acts as one.
        run_phase(0, 0, 60);

        // Long receiver stall while requests keep coming.
        @(posedge clk);
        hold_start = 1'b1;
        @(negedge clk);
        run_phase(16, 64, 300);

        run_phase(40, 12, 250);

        // Values above the maximum act as the maximum.
        run_phase(511, 127, 700);

        // Final stretch at full speed on both channels.
        @(posedge clk);
        idle_on = 1'b0;
        @(negedge clk);
        run_phase(256, 2, 200);

        repeat (30) @(negedge clk);
        if (!failed && sim_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
